@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of the animation timeline unit.
// Needs a signal named clock and, for the first macro, a signal named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ATU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ATU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/atu_pkg.sv @@
// Shared types and constants of the animation timeline unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package atu_pkg;

   localparam int DEFAULT_TIME_BITS     = 32;
   localparam int DEFAULT_DURATION_BITS = 24;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_DURATION    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_COUNT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_INSTANT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_TICKS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALTERNATE_DIR     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_AWAITS_SYNC_START = 3'd5;

   localparam logic [31:0] CURVE_DURATION_RESET  = 32'd1000000;
   localparam logic [16:0] ITERATION_COUNT_RESET = 17'd1;

   typedef enum logic [2:0] {
      RS_WAIT_TICK     = 3'd0,
      RS_WAIT_TARGET   = 3'd1,
      RS_WAIT_START    = 3'd2,
      RS_WAIT_DELETION = 3'd3,
      RS_RUNNING       = 3'd4,
      RS_PAUSED        = 3'd5,
      RS_FINISHED      = 3'd6,
      RS_ABORTED       = 3'd7
   } atu_run_state_type;

   typedef enum logic [1:0] {
      OP_NONE      = 2'd0,
      OP_SET_STATE = 2'd1,
      OP_SUSPEND   = 2'd2,
      OP_RESUME    = 2'd3
   } atu_op_type;

   typedef enum logic [2:0] {
      ATU_IDLE,
      ATU_CALC,
      ATU_DECIDE,
      ATU_DIVIDE,
      ATU_OUTPUT
   } atu_fsm_type;

   typedef struct packed {
      logic accept;
      logic calc;
      logic decide;
      logic div_step;
      logic out_load;
   } atu_cmd_type;

   typedef struct packed {
      logic need_div;
   } atu_status_type;

endpackage

@@ sv/atu_ctrl.sv @@
// Sequencing controller of the animation timeline unit.
// Uses atu_pkg for its state, command and status types.
module atu_ctrl #(
   parameter int STEPS = 34
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  atu_pkg::atu_status_type status,
   output atu_pkg::atu_cmd_type    cmd
);

   localparam int CNT_W = $clog2(STEPS);

   atu_pkg::atu_fsm_type state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         atu_pkg::ATU_IDLE: begin
            if (req_valid) begin
               state_in = atu_pkg::ATU_CALC;
            end
         end
         atu_pkg::ATU_CALC: begin
            state_in = atu_pkg::ATU_DECIDE;
         end
         atu_pkg::ATU_DECIDE: begin
            state_in = status.need_div ? atu_pkg::ATU_DIVIDE : atu_pkg::ATU_OUTPUT;
         end
         atu_pkg::ATU_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = atu_pkg::ATU_OUTPUT;
            end
         end
         atu_pkg::ATU_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = atu_pkg::ATU_IDLE;
            end
         end
         default: begin
            state_in = atu_pkg::ATU_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         atu_pkg::ATU_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         atu_pkg::ATU_CALC: begin
            cmd.calc = 1'b1;
         end
         atu_pkg::ATU_DECIDE: begin
            cmd.decide = 1'b1;
            cnt_in     = CNT_W'(STEPS - 1);
         end
         atu_pkg::ATU_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
         end
         atu_pkg::ATU_OUTPUT: begin
            cmd.out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            cmd = '0;
         end
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= atu_pkg::ATU_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/atu_datapath.sv @@
// Datapath of the animation timeline unit: registers, command logic, trim and divider.
// Uses atu_pkg for codes and the command and status types; driven by atu_ctrl.
module atu_datapath #(
   parameter int TIME_BITS     = atu_pkg::DEFAULT_TIME_BITS,
   parameter int DURATION_BITS = atu_pkg::DEFAULT_DURATION_BITS,
   parameter int CSR_W         = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  atu_pkg::atu_cmd_type             cmd,
   output atu_pkg::atu_status_type          status,
   input  logic [1:0]                       req_operation,
   input  logic [2:0]                       req_target_state,
   input  logic [TIME_BITS-1:0]             req_now,
   input  logic                             csr_write_en,
   input  logic [atu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]                 csr_wdata,
   output logic [2:0]                       rsp_state_now,
   output logic                             rsp_finished_flag,
   output logic [DURATION_BITS-1:0]         rsp_local_time
);

   localparam int WIDE_T = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int SW     = WIDE_T + 3;
   localparam int NB     = SW - 1;
   localparam int PW     = DURATION_BITS + 16;
   localparam int CW     = ((SW > PW) ? SW : PW) + 1;
   localparam int DB     = DURATION_BITS;

   // Configuration registers.
   logic [DB-1:0]        dur_ff;
   logic signed [16:0]   iter_ff;
   logic [TIME_BITS-1:0] start_ff;
   logic signed [31:0]   offset_ff;
   logic                 alt_ff;
   logic                 sync_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff    <= DB'(atu_pkg::CURVE_DURATION_RESET);
         iter_ff   <= atu_pkg::ITERATION_COUNT_RESET;
         start_ff  <= '0;
         offset_ff <= '0;
         alt_ff    <= 1'b0;
         sync_ff   <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            atu_pkg::CSR_CURVE_DURATION:    dur_ff    <= csr_wdata[DB-1:0];
            atu_pkg::CSR_ITERATION_COUNT:   iter_ff   <= csr_wdata[16:0];
            atu_pkg::CSR_START_INSTANT:     start_ff  <= csr_wdata[TIME_BITS-1:0];
            atu_pkg::CSR_OFFSET_TICKS:      offset_ff <= csr_wdata[31:0];
            atu_pkg::CSR_ALTERNATE_DIR:     alt_ff    <= csr_wdata[0];
            atu_pkg::CSR_AWAITS_SYNC_START: sync_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Run state, suspend flag, pause instant and paused total.
   atu_pkg::atu_run_state_type run_state_ff, run_state_in;
   logic                       susp_ff, susp_in;
   logic [TIME_BITS-1:0]       pause_ff, pause_in;
   logic [TIME_BITS-1:0]       total_ff, total_in;
   logic [TIME_BITS-1:0]       now_ff;
   atu_pkg::atu_run_state_type target;
   logic                       do_change;
   logic [TIME_BITS-1:0]       span;
   logic [TIME_BITS:0]         sum;

   always_comb begin
      target    = atu_pkg::atu_run_state_type'(req_target_state);
      do_change = 1'b0;
      susp_in   = susp_ff;
      unique case (atu_pkg::atu_op_type'(req_operation))
         atu_pkg::OP_NONE: begin
            do_change = 1'b0;
         end
         atu_pkg::OP_SET_STATE: begin
            do_change = !susp_ff;
         end
         atu_pkg::OP_SUSPEND: begin
            target    = atu_pkg::RS_PAUSED;
            do_change = !susp_ff;
            susp_in   = 1'b1;
         end
         atu_pkg::OP_RESUME: begin
            target    = atu_pkg::RS_RUNNING;
            do_change = 1'b1;
            susp_in   = 1'b0;
         end
         default: begin
            do_change = 1'b0;
         end
      endcase

      span = (req_now >= pause_ff) ? (req_now - pause_ff) : '0;
      sum  = {1'b0, total_ff} + {1'b0, span};

      run_state_in = run_state_ff;
      pause_in     = pause_ff;
      total_in     = total_ff;
      if (do_change) begin
         run_state_in = target;
         if (target == atu_pkg::RS_RUNNING && run_state_ff == atu_pkg::RS_PAUSED) begin
            total_in = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
         end else if (target == atu_pkg::RS_PAUSED) begin
            pause_in = req_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_state_ff <= atu_pkg::RS_WAIT_TARGET;
         susp_ff      <= 1'b0;
         pause_ff     <= '0;
         total_ff     <= '0;
      end else if (cmd.accept) begin
         run_state_ff <= run_state_in;
         susp_ff      <= susp_in;
         pause_ff     <= pause_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         now_ff <= req_now;
      end
   end

   // Trimmed time, elapsed time and the end-of-run product.
   logic signed [SW-1:0] t_ff, t_in;
   logic signed [SW-1:0] elapsed_ff, elapsed_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic signed [SW-1:0] now_x, pause_x, start_x, total_x, offset_x;

   always_comb begin
      now_x      = $signed({{(SW-TIME_BITS){1'b0}}, now_ff});
      pause_x    = $signed({{(SW-TIME_BITS){1'b0}}, pause_ff});
      start_x    = $signed({{(SW-TIME_BITS){1'b0}}, start_ff});
      total_x    = $signed({{(SW-TIME_BITS){1'b0}}, total_ff});
      offset_x   = $signed({{(SW-32){offset_ff[31]}}, offset_ff});
      t_in       = ((run_state_ff == atu_pkg::RS_PAUSED) ? pause_x : (now_x + offset_x))
                   - start_x - total_x;
      elapsed_in = now_x - start_x - total_x;
      prod_in    = {{DB{1'b0}}, iter_ff[15:0]} * {16'd0, dur_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         t_ff       <= t_in;
         elapsed_ff <= elapsed_in;
         prod_ff    <= prod_in;
      end
   end

   // Decision on the registered values.
   logic signed [CW-1:0] t_c, e_c, p_c, d_c;
   logic                 iter_neg, t_pos, clamp;
   logic                 fin_dec, need_div;
   logic [DB-1:0]        local_dec;

   always_comb begin
      t_c      = $signed({{(CW-SW){t_ff[SW-1]}}, t_ff});
      e_c      = $signed({{(CW-SW){elapsed_ff[SW-1]}}, elapsed_ff});
      p_c      = $signed({{(CW-PW){1'b0}}, prod_ff});
      d_c      = $signed({{(CW-DB){1'b0}}, dur_ff});
      iter_neg = iter_ff[16];
      t_pos    = !t_ff[SW-1] && (t_ff != '0);
      clamp    = !iter_neg && (t_c >= p_c);

      need_div  = 1'b0;
      local_dec = '0;
      priority if (!t_pos || iter_ff == '0) begin
         local_dec = '0;
      end else if (t_c < d_c) begin
         local_dec = t_ff[DB-1:0];
      end else if (clamp) begin
         local_dec = (alt_ff && !iter_ff[0]) ? '0 : dur_ff;
      end else if (dur_ff == '0) begin
         local_dec = '0;
      end else begin
         need_div = 1'b1;
      end

      priority if (run_state_ff == atu_pkg::RS_FINISHED || run_state_ff == atu_pkg::RS_ABORTED
                   || run_state_ff == atu_pkg::RS_WAIT_DELETION) begin
         fin_dec = 1'b1;
      end else if (sync_ff || run_state_ff != atu_pkg::RS_RUNNING || iter_neg) begin
         fin_dec = 1'b0;
      end else begin
         fin_dec = (p_c <= e_c);
      end
   end

   assign status.need_div = need_div;

   // Restoring divider: one quotient bit per step, only the last bit is kept.
   logic          fin_ff;
   logic [DB-1:0] local_ff;
   logic          need_div_ff;
   logic [NB-1:0] dividend_ff;
   logic [DB-1:0] rem_ff, rem_in;
   logic          qbit_ff, qbit_in;
   logic [DB:0]   rem_sh, rem_diff;
   logic [DB-1:0] div_res;

   always_comb begin
      rem_sh   = {rem_ff, dividend_ff[NB-1]};
      rem_diff = rem_sh - {1'b0, dur_ff};
      qbit_in  = (rem_sh >= {1'b0, dur_ff});
      rem_in   = qbit_in ? rem_diff[DB-1:0] : rem_sh[DB-1:0];
      div_res  = (alt_ff && qbit_ff) ? (dur_ff - rem_ff) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         fin_ff      <= fin_dec;
         local_ff    <= local_dec;
         need_div_ff <= need_div;
         dividend_ff <= t_ff[NB-1:0];
         rem_ff      <= '0;
         qbit_ff     <= 1'b0;
      end else if (cmd.div_step) begin
         dividend_ff <= {dividend_ff[NB-2:0], 1'b0};
         rem_ff      <= rem_in;
         qbit_ff     <= qbit_in;
      end
   end

   // Output word register.
   logic [2:0]    state_out_ff;
   logic          fin_out_ff;
   logic [DB-1:0] local_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         state_out_ff <= run_state_ff;
         fin_out_ff   <= fin_ff;
         local_out_ff <= need_div_ff ? div_res : local_ff;
      end
   end

   assign rsp_state_now     = state_out_ff;
   assign rsp_finished_flag = fin_out_ff;
   assign rsp_local_time    = local_out_ff;

endmodule

@@ sv/animation_timeline_unit.sv @@
// Top level of the animation timeline unit: controller and datapath.
// Depends on atu_pkg, atu_ctrl and atu_datapath.
//
// Usage: each request word carries an operation (none, set run state, suspend,
// resume), a target run state and the current time. The command is applied at
// acceptance; the response word then gives the run state, the finished flag and
// the local curve time. Both channels use valid and stall; a word moves at a
// rising edge with valid high and stall low.
// After acceptance the controller passes the calc and decide states and, when
// the time must be wrapped into an iteration, the divide state, before the output
// state loads the response register. That wrap runs a restoring divider one bit
// per cycle.
// Only one word is worked on at a time; the next request is taken as soon as the
// response sits in the output register, even while the receiver stalls it. A
// stalled response holds, and a finished word waits there until it is taken.
// Reset (synchronous, active high) restores the configuration registers to
// their defaults, sets the run state to waiting for target and clears the
// suspend flag, the pause instant and the paused total.
// Configuration registers are written through csr_write_en, csr_index, csr_wdata.
module animation_timeline_unit #(
   parameter int TIME_BITS     = atu_pkg::DEFAULT_TIME_BITS,
   parameter int DURATION_BITS = atu_pkg::DEFAULT_DURATION_BITS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic [1:0]                                   req_operation,
   input  logic [2:0]                                   req_target_state,
   input  logic [TIME_BITS-1:0]                         req_now,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic [2:0]                                   rsp_state_now,
   output logic                                         rsp_finished_flag,
   output logic [DURATION_BITS-1:0]                     rsp_local_time,
   input  logic                                         csr_write_en,
   input  logic [atu_pkg::CSR_INDEX_W-1:0]              csr_index,
   input  logic [((TIME_BITS > 32) ? TIME_BITS : 32)-1:0] csr_wdata
);

   localparam int CSR_W = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int STEPS = CSR_W + 2;

   atu_pkg::atu_cmd_type    cmd;
   atu_pkg::atu_status_type status;

   atu_ctrl #(
      .STEPS(STEPS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   atu_datapath #(
      .TIME_BITS    (TIME_BITS),
      .DURATION_BITS(DURATION_BITS),
      .CSR_W        (CSR_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_target_state (req_target_state),
      .req_now          (req_now),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_state_now    (rsp_state_now),
      .rsp_finished_flag(rsp_finished_flag),
      .rsp_local_time   (rsp_local_time)
   );

endmodule

@@ sv/atu_checker.sv @@
// Port-level checker of the animation timeline unit and its bind statement.
// Depends on assert_macros.svh, atu_pkg and the top level animation_timeline_unit.
`include "assert_macros.svh"

module atu_checker #(
   parameter int DURATION_BITS = atu_pkg::DEFAULT_DURATION_BITS
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [2:0]               rsp_state_now,
   input logic                     rsp_finished_flag,
   input logic [DURATION_BITS-1:0] rsp_local_time
);

   logic rsp_final;
   logic rsp_paused;
   logic rsp_wait;

   assign rsp_final  = rsp_state_now == atu_pkg::RS_FINISHED
                       || rsp_state_now == atu_pkg::RS_ABORTED
                       || rsp_state_now == atu_pkg::RS_WAIT_DELETION;
   assign rsp_paused = rsp_state_now == atu_pkg::RS_PAUSED;
   assign rsp_wait   = rsp_valid && rsp_stall;

   `ATU_ASSERT_ALWAYS(a_reset_clears_rsp, $past(reset) |-> !rsp_valid, "response valid after reset")

   `ATU_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "request taken while busy")

   `ATU_ASSERT(a_final_states_finished, rsp_valid && rsp_final |-> rsp_finished_flag, "final state not finished")

   `ATU_ASSERT(a_paused_not_finished, rsp_valid && rsp_paused |-> !rsp_finished_flag, "paused state finished")

   `ATU_ASSERT(a_rsp_holds, rsp_wait |=> rsp_valid && $stable(rsp_local_time), "stalled word changed")

endmodule

bind animation_timeline_unit atu_checker #(
   .DURATION_BITS(DURATION_BITS)
) u_atu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_state_now    (rsp_state_now),
   .rsp_finished_flag(rsp_finished_flag),
   .rsp_local_time   (rsp_local_time)
);
